// ===== sv/gclp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and character constants of the G-code line parser.
package gclp_pkg;

  localparam int LINE_MAX        = 256;
  localparam int LEN_W           = $clog2(LINE_MAX);
  localparam int PARAM_COUNT     = 26;
  localparam int IDX_W           = $clog2(PARAM_COUNT);
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 6;
  localparam int INT_W           = 32 - FRAC_BITS + 1;
  localparam int INT_LIMIT       = 1 << (32 - FRAC_BITS);
  localparam int FRAC_W          = 20;

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CMD   = 3'd1;
  localparam logic [2:0] ERR_BAD_NUM   = 3'd2;
  localparam logic [2:0] ERR_BAD_PARAM = 3'd3;
  localparam logic [2:0] ERR_BAD_VALUE = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_M     = 8'h4D;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] text_byte;
    logic [7:0] param_letter;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               cmd_letter;
    logic [15:0]        cmd_number;
    logic signed [31:0] param_value;
    logic [2:0]         error_code;
  } out_item_t;

  // Write and clear requests from the parser to the parameter table.
  typedef struct packed {
    logic             clear;
    logic             wr_en;
    logic [IDX_W-1:0] idx;
    logic [31:0]      mag;
    logic             neg;
  } tbl_wr_t;

endpackage

// ===== sv/gclp_fixconv.sv =====
`timescale 1ns / 1ps
// Converts a finished parameter token into a saturated Q16.16 magnitude for the given sign.
module gclp_fixconv (
  input  logic [gclp_pkg::INT_W-1:0]  int_acc,
  input  logic                        int_big,
  input  logic [gclp_pkg::FRAC_W-1:0] frac_acc,
  input  logic                        negative,
  output logic [31:0]                 mag
);

  // The fraction is kept scaled to millionths, so the rounded Q16 fraction is
  // floor((F * 2^16 + 500000) / 10^6) = floor((F * 1024 + 7812) / 15625).
  // The quotient by 15625 is an exact reciprocal multiply for inputs below 2^30.
  localparam logic [30:0] RECIP       = 31'd1125899907;
  localparam int          RECIP_SHIFT = 44;
  localparam logic [29:0] ROUND_BIAS  = 30'd7812;
  localparam logic [32:0] POS_MAX     = 33'h0_7FFF_FFFF;
  localparam logic [32:0] NEG_MAX     = 33'h0_8000_0000;

  logic [29:0] scaled;
  logic [60:0] prod;
  logic [16:0] frac_q;
  logic [32:0] whole;

  assign scaled = {frac_acc, 10'b0} + ROUND_BIAS;
  assign prod   = 61'(scaled) * 61'(RECIP);
  assign frac_q = prod[RECIP_SHIFT+16:RECIP_SHIFT];
  assign whole  = {int_acc[16:0], 16'b0} + 33'(frac_q);

  always_comb begin
    if (negative) begin
      mag = (int_big || whole > NEG_MAX) ? NEG_MAX[31:0] : whole[31:0];
    end else begin
      mag = (int_big || whole > POS_MAX) ? POS_MAX[31:0] : whole[31:0];
    end
  end

endmodule

// ===== sv/gclp_ptable.sv =====
`timescale 1ns / 1ps
// Parameter table: 26 sign-magnitude entries with registered clear and combinational read.
module gclp_ptable (
  input  logic               clk,
  input  logic               rst,
  input  gclp_pkg::tbl_wr_t  wr,
  input  logic [7:0]         rd_letter,
  output logic signed [31:0] rd_value
);

  logic [31:0]                      mag [gclp_pkg::PARAM_COUNT];
  logic [gclp_pkg::PARAM_COUNT-1:0] neg;
  logic [7:0]                       offset;
  logic [gclp_pkg::IDX_W-1:0]       rd_idx;
  logic                             in_range;

  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      for (int i = 0; i < gclp_pkg::PARAM_COUNT; i++) begin
        mag[i] <= 32'd0;
      end
      neg <= '0;
    end else if (wr.wr_en) begin
      mag[wr.idx] <= wr.mag;
      neg[wr.idx] <= wr.neg;
    end
  end

  assign offset   = rd_letter - gclp_pkg::CH_A;
  assign in_range = (rd_letter >= gclp_pkg::CH_A) &&
                    (offset < 8'(gclp_pkg::PARAM_COUNT));
  assign rd_idx   = offset[gclp_pkg::IDX_W-1:0];

  always_comb begin
    if (!in_range) begin
      rd_value = 32'sd0;
    end else if (neg[rd_idx]) begin
      rd_value = signed'(32'd0 - mag[rd_idx]);
    end else begin
      rd_value = signed'(mag[rd_idx]);
    end
  end

endmodule

// ===== sv/gclp_parser.sv =====
`timescale 1ns / 1ps
// Line parse state and per-transaction update logic of the G-code parser.
module gclp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  gclp_pkg::in_item_t  item,
  output logic                res_valid,
  output gclp_pkg::out_item_t res
);

  localparam logic [2:0] PH_GAP    = 3'd0;
  localparam logic [2:0] PH_LETTER = 3'd1;
  localparam logic [2:0] PH_SIGN   = 3'd2;
  localparam logic [2:0] PH_INT    = 3'd3;
  localparam logic [2:0] PH_DOT    = 3'd4;
  localparam logic [2:0] PH_FRAC   = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  logic [2:0]                  phase, phase_next;
  logic [gclp_pkg::LEN_W-1:0]  line_len, line_len_next;
  logic                        token_seen, token_seen_next;
  logic [2:0]                  first_error, first_error_next;
  logic                        negative, negative_next;
  logic [gclp_pkg::INT_W-1:0]  int_acc, int_acc_next;
  logic                        int_big, int_big_next;
  logic [gclp_pkg::FRAC_W-1:0] frac_acc, frac_acc_next;
  logic [2:0]                  frac_cnt, frac_cnt_next;
  logic [gclp_pkg::IDX_W-1:0]  letter_idx, letter_idx_next;
  logic                        last_letter, last_letter_next;
  logic [15:0]                 last_number, last_number_next;

  gclp_pkg::tbl_wr_t tw;
  logic signed [31:0] rd_value;
  logic [31:0]        fix_mag;

  logic [7:0]  c;
  logic [3:0]  digit;
  logic [2:0]  bad;
  logic [20:0] int_prod;
  logic [7:0]  letter_off;
  logic        do_fin;
  logic        to_skip;
  logic        is_lf;
  logic [2:0]  lf_err;
  logic        report;

  // Weight of the next fraction digit, in millionths.
  function automatic logic [gclp_pkg::FRAC_W-1:0] frac_weight(input logic [2:0] n);
    logic [gclp_pkg::FRAC_W-1:0] w;
    begin
      case (n)
        3'd0:    w = 20'd100000;
        3'd1:    w = 20'd10000;
        3'd2:    w = 20'd1000;
        3'd3:    w = 20'd100;
        3'd4:    w = 20'd10;
        3'd5:    w = 20'd1;
        default: w = 20'd0;
      endcase
      return w;
    end
  endfunction

  gclp_fixconv u_fixconv (
    .int_acc  (int_acc),
    .int_big  (int_big),
    .frac_acc (frac_acc),
    .negative (negative),
    .mag      (fix_mag)
  );

  gclp_ptable u_ptable (
    .clk       (clk),
    .rst       (rst),
    .wr        (tw),
    .rd_letter (item.param_letter),
    .rd_value  (rd_value)
  );

  assign c          = item.text_byte;
  assign digit      = 4'(c - gclp_pkg::CH_ZERO);
  assign bad        = token_seen ? gclp_pkg::ERR_BAD_VALUE : gclp_pkg::ERR_BAD_NUM;
  assign int_prod   = {1'b0, int_acc, 3'b0} + {3'b0, int_acc, 1'b0} + 21'(digit);
  assign letter_off = c - gclp_pkg::CH_A;

  always_comb begin
    phase_next       = phase;
    line_len_next    = line_len;
    token_seen_next  = token_seen;
    first_error_next = first_error;
    negative_next    = negative;
    int_acc_next     = int_acc;
    int_big_next     = int_big;
    frac_acc_next    = frac_acc;
    frac_cnt_next    = frac_cnt;
    letter_idx_next  = letter_idx;
    last_letter_next = last_letter;
    last_number_next = last_number;
    tw               = '0;
    do_fin           = 1'b0;
    to_skip          = 1'b0;
    is_lf            = 1'b0;
    lf_err           = gclp_pkg::ERR_NONE;
    report           = 1'b0;
    res_valid        = 1'b0;
    res              = '0;

    unique case (item.opcode)
      gclp_pkg::OP_READ: begin
        res_valid       = 1'b1;
        res.result_kind = gclp_pkg::KIND_READ;
        res.param_value = rd_value;
      end
      gclp_pkg::OP_CLEAR: begin
        tw.clear         = 1'b1;
        last_letter_next = 1'b0;
        last_number_next = 16'd0;
      end
      gclp_pkg::OP_FEED: begin
        if (c == gclp_pkg::CH_LF) begin
          do_fin = 1'b1;
          is_lf  = 1'b1;
        end else if (line_len < gclp_pkg::LEN_W'(gclp_pkg::LINE_MAX - 1)) begin
          line_len_next = line_len + 1'b1;
          if (phase != PH_SKIP) begin
            if (c == gclp_pkg::CH_SEMI || c == gclp_pkg::CH_NUL) begin
              do_fin  = 1'b1;
              to_skip = 1'b1;
            end else if (c == gclp_pkg::CH_SPACE || c == gclp_pkg::CH_CR) begin
              do_fin = 1'b1;
            end else if (phase == PH_GAP) begin
              // Start of a token: command letter first, then parameter letters.
              if (!token_seen) begin
                if (c == gclp_pkg::CH_G || c == gclp_pkg::CH_M) begin
                  last_letter_next = (c == gclp_pkg::CH_M);
                  phase_next       = PH_LETTER;
                end else begin
                  first_error_next = gclp_pkg::ERR_BAD_CMD;
                  phase_next       = PH_SKIP;
                end
              end else if (c >= gclp_pkg::CH_A &&
                           letter_off < 8'(gclp_pkg::PARAM_COUNT)) begin
                letter_idx_next = letter_off[gclp_pkg::IDX_W-1:0];
                phase_next      = PH_LETTER;
              end else begin
                first_error_next = gclp_pkg::ERR_BAD_PARAM;
                phase_next       = PH_SKIP;
              end
              negative_next = 1'b0;
              int_acc_next  = '0;
              int_big_next  = 1'b0;
              frac_acc_next = '0;
              frac_cnt_next = 3'd0;
            end else if (c == gclp_pkg::CH_PLUS || c == gclp_pkg::CH_MINUS) begin
              if (phase == PH_LETTER) begin
                negative_next = (c == gclp_pkg::CH_MINUS);
                phase_next    = PH_SIGN;
              end else begin
                first_error_next = bad;
                phase_next       = PH_SKIP;
              end
            end else if (c >= gclp_pkg::CH_ZERO && c <= gclp_pkg::CH_NINE) begin
              if (phase == PH_DOT || phase == PH_FRAC) begin
                // Digits past the kept precision are checked and dropped.
                if (frac_cnt < 3'(gclp_pkg::MAX_FRAC_DIGITS)) begin
                  frac_acc_next = frac_acc + gclp_pkg::FRAC_W'(digit * frac_weight(frac_cnt));
                  frac_cnt_next = frac_cnt + 1'b1;
                end
                phase_next = PH_FRAC;
              end else begin
                int_acc_next = int_prod[gclp_pkg::INT_W-1:0];
                if (int_prod > 21'(gclp_pkg::INT_LIMIT)) begin
                  int_big_next = 1'b1;
                end
                phase_next = PH_INT;
              end
            end else if (c == gclp_pkg::CH_DOT && token_seen) begin
              if (phase == PH_LETTER || phase == PH_SIGN) begin
                phase_next = PH_DOT;
              end else if (phase == PH_INT) begin
                phase_next = PH_FRAC;
              end else begin
                first_error_next = bad;
                phase_next       = PH_SKIP;
              end
            end else begin
              first_error_next = bad;
              phase_next       = PH_SKIP;
            end
          end
        end
      end
      default: begin
      end
    endcase

    // The line keeps only its first error. After a failure the phase stays in skip,
    // so this block is not entered and the first-error check never meets an earlier error.
    if (do_fin && phase != PH_GAP && phase != PH_SKIP) begin
      if (phase == PH_LETTER || phase == PH_INT || phase == PH_FRAC) begin
        if (!token_seen) begin
          last_number_next = negative ? (16'd0 - int_acc[15:0]) : int_acc[15:0];
          token_seen_next  = 1'b1;
        end else begin
          tw.wr_en = 1'b1;
          tw.idx   = letter_idx;
          tw.mag   = fix_mag;
          tw.neg   = negative;
        end
        phase_next = PH_GAP;
      end else begin
        if (first_error == gclp_pkg::ERR_NONE) begin
          first_error_next = bad;
        end
        phase_next = PH_SKIP;
      end
    end

    if (to_skip) begin
      phase_next = PH_SKIP;
    end

    if (is_lf) begin
      lf_err = first_error_next;
      report = (first_error_next != gclp_pkg::ERR_NONE) || token_seen_next;
      res_valid        = report;
      res.result_kind  = (lf_err != gclp_pkg::ERR_NONE) ? gclp_pkg::KIND_REJECT
                                                         : gclp_pkg::KIND_CMD;
      res.error_code   = lf_err;
      phase_next       = PH_GAP;
      line_len_next    = '0;
      token_seen_next  = 1'b0;
      first_error_next = gclp_pkg::ERR_NONE;
    end

    res.cmd_letter = last_letter_next;
    res.cmd_number = last_number_next;

    // State changes only when the transaction actually leaves the input register.
    if (!step) begin
      tw        = '0;
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_GAP;
      line_len    <= '0;
      token_seen  <= 1'b0;
      first_error <= gclp_pkg::ERR_NONE;
      negative    <= 1'b0;
      int_acc     <= '0;
      int_big     <= 1'b0;
      frac_acc    <= '0;
      frac_cnt    <= 3'd0;
      letter_idx  <= '0;
      last_letter <= 1'b0;
      last_number <= 16'd0;
    end else if (step) begin
      phase       <= phase_next;
      line_len    <= line_len_next;
      token_seen  <= token_seen_next;
      first_error <= first_error_next;
      negative    <= negative_next;
      int_acc     <= int_acc_next;
      int_big     <= int_big_next;
      frac_acc    <= frac_acc_next;
      frac_cnt    <= frac_cnt_next;
      letter_idx  <= letter_idx_next;
      last_letter <= last_letter_next;
      last_number <= last_number_next;
    end
  end

endmodule

// ===== sv/gcode_line_parser_core.sv =====
`timescale 1ns / 1ps
// Top level of the G-code line parser: input register, parser and result register.
//
//   channel   signals                             direction   payload type
//   item      item_valid, item_ready, item        in          gclp_pkg::in_item_t
//   result    result_valid, result_ready, result  out         gclp_pkg::out_item_t
//
// One transaction per clock while the result register is free: each item sits in
// the input register, and the parser updates its state and the parameter table at
// the edge where the item leaves it. A result is loaded into the result register at
// that same edge, so it is offered after the input register and the result register.
// The input register advances whenever the result register is empty or drained,
// so a new item is taken in the same cycle that a waiting result is taken.
// Reset (rst, synchronous) empties both registers, returns the parser to line
// start and clears the 26-entry table.
module gcode_line_parser_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  gclp_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_ready,
  output gclp_pkg::out_item_t result
);

  logic                hold_valid;
  gclp_pkg::in_item_t  hold_item;
  logic                out_free;
  logic                step;
  logic                res_valid;
  gclp_pkg::out_item_t res;

  assign out_free   = !result_valid || result_ready;
  assign step       = hold_valid && out_free;
  assign item_ready = !hold_valid || step;

  gclp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (hold_item),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      hold_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      result <= res;
    end
  end

endmodule

// ===== tb/gcode_line_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard of the G-code line parser: tracks the line state, predicts results and compares.
module gcode_line_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  gclp_pkg::in_item_t  item,
  input  logic                result_valid,
  input  logic                result_ready,
  input  gclp_pkg::out_item_t result,
  output int                  mismatches,
  output int                  pending
);
  import gclp_pkg::*;

  localparam longint unsigned MANT_CAP = 64'd1 << 47;
  localparam int PRINT_CAP = 100;

  typedef enum logic [2:0] {
    SCAN_GAP, SCAN_LETTER, SCAN_SIGN, SCAN_INT, SCAN_DOT, SCAN_FRAC, SCAN_SKIP
  } scan_t;

  scan_t           scan;
  int unsigned     col;
  bit              have_cmd;
  logic [2:0]      line_err;
  bit              neg;
  longint unsigned mant;
  int unsigned     frac_n;
  int unsigned     slot;
  logic [31:0]     params [PARAM_COUNT];
  logic            cmd_m;
  logic [15:0]     cmd_num;

  out_item_t       expected_q [$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  task automatic log_mismatch(input string what, input logic [63:0] got,
                              input logic [63:0] want);
    if (mismatches < PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void clear_model();
    scan = SCAN_GAP;
    col = 0;
    have_cmd = 0;
    line_err = ERR_NONE;
    neg = 0;
    mant = 0;
    frac_n = 0;
    slot = 0;
    foreach (params[i]) params[i] = '0;
    cmd_m = 0;
    cmd_num = '0;
  endfunction

  function automatic void flag_error(input logic [2:0] code);
    if (line_err == ERR_NONE)
      line_err = code;
    scan = SCAN_SKIP;
  endfunction

  // Decimal mantissa with frac_n fraction digits to Q16.16, rounded half up, saturated.
  function automatic logic [31:0] q16_value();
    longint unsigned p, whole, rem, q;
    p = 1;
    repeat (frac_n) p = p * 10;
    whole = mant / p;
    rem = mant % p;
    if (whole > (64'd1 << (32 - FRAC_BITS)))
      q = 64'd1 << 33;
    else
      q = (whole << FRAC_BITS) + (((rem << FRAC_BITS) + p / 2) / p);
    if (!neg)
      return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    if (q > 64'h8000_0000)
      q = 64'h8000_0000;
    return 32'd0 - q[31:0];
  endfunction

  function automatic void close_token();
    longint unsigned v;
    if (scan == SCAN_GAP || scan == SCAN_SKIP)
      return;
    if (scan != SCAN_LETTER && scan != SCAN_INT && scan != SCAN_FRAC) begin
      flag_error(have_cmd ? ERR_BAD_VALUE : ERR_BAD_NUM);
      return;
    end
    if (!have_cmd) begin
      v = neg ? (64'd0 - mant) : mant;
      cmd_num = v[15:0];
      have_cmd = 1;
    end else begin
      params[slot] = q16_value();
    end
    scan = SCAN_GAP;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    if (!have_cmd) begin
      if (c != CH_G && c != CH_M) begin
        flag_error(ERR_BAD_CMD);
        return;
      end
      cmd_m = (c == CH_M);
    end else begin
      if (c < CH_A || int'(c) >= int'(CH_A) + PARAM_COUNT) begin
        flag_error(ERR_BAD_PARAM);
        return;
      end
      slot = int'(c) - int'(CH_A);
    end
    neg = 0;
    mant = 0;
    frac_n = 0;
    scan = SCAN_LETTER;
  endfunction

  // The command number wraps at 16 bits; parameter mantissas stick at the cap.
  function automatic void push_digit(input int unsigned d);
    if (!have_cmd)
      mant = (mant * 10 + d) & 64'hFFFF;
    else if (mant > (MANT_CAP - d) / 10)
      mant = MANT_CAP;
    else
      mant = mant * 10 + d;
  endfunction

  function automatic void take_body(input logic [7:0] c);
    logic [2:0] bad;
    bad = have_cmd ? ERR_BAD_VALUE : ERR_BAD_NUM;
    if (c == CH_PLUS || c == CH_MINUS) begin
      if (scan != SCAN_LETTER) begin
        flag_error(bad);
        return;
      end
      neg = (c == CH_MINUS);
      scan = SCAN_SIGN;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      if (scan == SCAN_DOT || scan == SCAN_FRAC) begin
        if (frac_n < MAX_FRAC_DIGITS) begin
          push_digit(32'(c - CH_ZERO));
          frac_n++;
        end
        scan = SCAN_FRAC;
      end else begin
        push_digit(32'(c - CH_ZERO));
        scan = SCAN_INT;
      end
    end else if (c == CH_DOT && have_cmd) begin
      if (scan == SCAN_LETTER || scan == SCAN_SIGN)
        scan = SCAN_DOT;
      else if (scan == SCAN_INT)
        scan = SCAN_FRAC;
      else
        flag_error(bad);
    end else begin
      flag_error(bad);
    end
  endfunction

  function automatic bit predict_item(input in_item_t it, output out_item_t r);
    bit emits;
    logic [7:0] c;
    r = '0;
    emits = 0;
    c = it.text_byte;
    case (it.opcode)
      OP_READ: begin
        r.result_kind = KIND_READ;
        if (it.param_letter >= CH_A && int'(it.param_letter) < int'(CH_A) + PARAM_COUNT)
          r.param_value = params[int'(it.param_letter) - int'(CH_A)];
        emits = 1;
      end
      OP_CLEAR: begin
        foreach (params[i]) params[i] = '0;
        cmd_m = 0;
        cmd_num = '0;
      end
      OP_NOP: ;
      default: begin
        if (c == CH_LF) begin
          close_token();
          emits = (line_err != ERR_NONE) || have_cmd;
          if (line_err != ERR_NONE) begin
            r.result_kind = KIND_REJECT;
            r.error_code = line_err;
          end else begin
            r.result_kind = KIND_CMD;
          end
          scan = SCAN_GAP;
          col = 0;
          have_cmd = 0;
          line_err = ERR_NONE;
        end else if (col < LINE_MAX - 1) begin
          col++;
          if (scan != SCAN_SKIP) begin
            if (c == CH_SEMI || c == CH_NUL) begin
              close_token();
              scan = SCAN_SKIP;
            end else if (c == CH_SPACE || c == CH_CR) begin
              close_token();
            end else if (scan == SCAN_GAP) begin
              open_token(c);
            end else begin
              take_body(c);
            end
          end
        end
      end
    endcase
    r.cmd_letter = cmd_m;
    r.cmd_number = cmd_num;
    return emits;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (rst) begin
      clear_model();
      expected_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          log_mismatch("result with nothing expected", 64'(result), '0);
        end else begin
          want = expected_q.pop_front();
          if (result.result_kind !== want.result_kind)
            log_mismatch("result_kind", 64'(result.result_kind), 64'(want.result_kind));
          if (result.cmd_letter !== want.cmd_letter)
            log_mismatch("cmd_letter", 64'(result.cmd_letter), 64'(want.cmd_letter));
          if (result.cmd_number !== want.cmd_number)
            log_mismatch("cmd_number", 64'(result.cmd_number), 64'(want.cmd_number));
          if (result.param_value !== want.param_value)
            log_mismatch("param_value", 64'(result.param_value), 64'(want.param_value));
          if (result.error_code !== want.error_code)
            log_mismatch("error_code", 64'(result.error_code), 64'(want.error_code));
        end
      end
      if (item_valid && item_ready) begin
        if (predict_item(item, fresh))
          expected_q.push_back(fresh);
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== tb/tb_gcode_line_parser_core.sv =====
`timescale 1ns / 1ps
// Testbench top of the G-code line parser: clock, reset, line traffic, back-pressure and verdict.
module tb_gcode_line_parser_core;
  import gclp_pkg::*;

  localparam int ITEM_GOAL   = 2000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FROM   = 1000;
  localparam int CALM_TO     = 1300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  int        mismatches;
  int        pending;
  int        sent = 0;
  int        cycles = 0;
  bit        calm = 0;
  bit        hold_rx = 0;
  logic [7:0] line_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gcode_line_parser_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  gcode_line_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_rx)
      result_ready <= 1'b0;
    else if (calm)
      result_ready <= 1'b1;
    else
      result_ready <= ($urandom_range(0, 99) >= 22);
  end

  // Long receiver stall while the sender keeps offering, so both registers fill up.
  initial begin
    wait (sent >= 400);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic send(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] letter);
    bit quiet;
    item_valid <= 1'b1;
    item <= '{op, ch, letter};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sent++;
    quiet = (sent >= CALM_FROM && sent < CALM_TO);
    calm <= quiet;
    while (!quiet && $urandom_range(0, 99) < 22) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic side_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70)
      send(OP_READ, 8'($urandom_range(0, 255)),
           CH_A + 8'($urandom_range(0, PARAM_COUNT - 1)));
    else if (r < 85)
      send(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else if (r < 93)
      send(OP_NOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    else
      send(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      line_q.push_back(s[i]);
  endtask

  // Sends the line built so far plus its line feed; other operations may cut in mid-line.
  task automatic end_line(input bit mixed);
    line_q.push_back(CH_LF);
    foreach (line_q[i]) begin
      if (mixed && $urandom_range(0, 99) < 2)
        side_op();
      send(OP_FEED, line_q[i], 8'($urandom_range(0, 255)));
    end
    line_q.delete();
  endtask

  task automatic add_sign();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      line_q.push_back(CH_MINUS);
    else if (r < 22)
      line_q.push_back(CH_PLUS);
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_gap();
    repeat ($urandom_range(1, 2))
      line_q.push_back(($urandom_range(0, 99) < 15) ? CH_CR : CH_SPACE);
  endtask

  task automatic add_junk(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      line_q.push_back((b == CH_LF) ? CH_SPACE : b);
    end
  endtask

  task automatic random_line(input bit long_line);
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      add_junk(0);
      repeat ($urandom_range(0, 2)) line_q.push_back(CH_SPACE);
    end else if (r < 10) begin
      add_junk($urandom_range(1, 12));
    end else begin
      if (long_line)
        repeat ($urandom_range(235, 265)) line_q.push_back(CH_SPACE);
      else if ($urandom_range(0, 9) == 0)
        line_q.push_back(CH_SPACE);
      r = $urandom_range(0, 99);
      if (r < 90)
        line_q.push_back($urandom_range(0, 1) ? CH_M : CH_G);
      else
        add_junk(1);
      add_sign();
      r = $urandom_range(0, 99);
      add_digits((r < 10) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 12));
      n = $urandom_range(0, 4);
      repeat (n) begin
        add_gap();
        if ($urandom_range(0, 99) < 94)
          line_q.push_back(CH_A + 8'($urandom_range(0, PARAM_COUNT - 1)));
        else
          add_junk(1);
        add_sign();
        r = $urandom_range(0, 99);
        add_digits((r < 15) ? 0 : (r < 85) ? $urandom_range(1, 4) : $urandom_range(5, 14));
        if ($urandom_range(0, 99) < 45) begin
          line_q.push_back(CH_DOT);
          add_digits($urandom_range(0, 9));
        end
        if ($urandom_range(0, 99) < 4)
          add_junk(1);
      end
      r = $urandom_range(0, 99);
      if (r < 12) begin
        line_q.push_back(CH_SEMI);
        add_junk($urandom_range(0, 6));
      end else if (r < 16) begin
        line_q.push_back(CH_NUL);
        add_junk($urandom_range(0, 4));
      end else if (r < 36) begin
        add_gap();
      end
      // Occasional stray bytes anywhere in the line.
      foreach (line_q[i])
        if ($urandom_range(0, 99) < 3)
          line_q[i] = 8'($urandom_range(0, 255));
    end
    end_line(1'b1);
  endtask

  initial begin
    int lines;
    lines = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Negative command number wraps, fraction-only value, bare letter, CR separator.
    push_text("G-1 X.5 Z");
    line_q.push_back(CH_CR);
    end_line(1'b0);
    send(OP_READ, 8'h00, "X");
    send(OP_READ, 8'hFF, "Z");
    send(OP_READ, 8'h00, 8'h5B);
    send(OP_READ, 8'h00, CH_A - 8'd1);
    push_text("M9e");
    end_line(1'b0);
    push_text("T");
    end_line(1'b0);
    send(OP_NOP, CH_LF, "X");
    send(OP_CLEAR, 8'h00, 8'h00);
    send(OP_READ, 8'h00, "X");

    while (sent < ITEM_GOAL) begin
      random_line(lines == 3 || $urandom_range(0, 79) == 0);
      lines++;
      if ($urandom_range(0, 99) < 30)
        side_op();
    end
    item_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
